[design/k_way_merge_engine_macros.svh]
// Assertion macros for the k-way merge engine.
// Included by the modules that carry assertions; no other dependencies.
`ifndef K_WAY_MERGE_ENGINE_MACROS_SVH
`define K_WAY_MERGE_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define KWM_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define KWM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define KWM_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define KWM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[design/kwm_pkg.sv]
// Shared constants and types of the k-way merge engine.
// No dependencies; imported by kwm_front, kwm_back, the top level and the bench.
`timescale 1ns / 1ps
`default_nettype none
package kwm_pkg;
    localparam int KEY_W        = 64;
    localparam int CFG_W        = 5;
    localparam int SRC_W        = 4;
    localparam int DEF_MAX_RUNS = 16;
    localparam logic [CFG_W-1:0] RUN_COUNT_RST = 5'd16;

    typedef struct packed {
        logic push;
        logic pop;
    } cmd_flags_t;

    typedef struct packed {
        logic pop_done;
        logic rearm;
    } back_stat_t;
endpackage
`default_nettype wire

[design/kwm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module kwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[design/kwm_cmd_fifo.sv]
// Two-entry request queue between the front and back ends.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps
`default_nettype none
module kwm_cmd_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic      [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

[design/kwm_front.sv]
// Front end: holds run_count, accepts input items and classifies each as a
// head load or a refill, with or without a pop. Uses kwm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kwm_front #(
    parameter int MAX_RUNS = kwm_pkg::DEF_MAX_RUNS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [kwm_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [kwm_pkg::KEY_W-1:0]     key_value,
    input  wire logic                          run_empty,
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output logic [kwm_pkg::KEY_W-1:0]          cmd_key,
    output logic [$clog2(MAX_RUNS)-1:0]        cmd_run,
    output kwm_pkg::cmd_flags_t                cmd_flags,
    input  wire kwm_pkg::back_stat_t           stat,
    input  wire logic [$clog2(MAX_RUNS)-1:0]   last_run
);
    import kwm_pkg::*;

    localparam int RW = $clog2(MAX_RUNS);
    localparam int CW = $clog2(MAX_RUNS + 1);

    logic [CFG_W-1:0] run_count_reg;
    logic [CW-1:0]    heads_reg, heads_next;
    logic             pop_pend_reg;
    logic [31:0]      n32;
    logic [CW-1:0]    n_eff;
    logic             loading, accept;

    // Effective run count: zero acts as one, large values saturate.
    always_comb
    begin
        n32 = {{(32-CFG_W){1'b0}}, run_count_reg};
        if (n32 == 32'd0)
        begin
            n32 = 32'd1;
        end
        else if (n32 > 32'(MAX_RUNS))
        begin
            n32 = 32'(MAX_RUNS);
        end
        n_eff = n32[CW-1:0];
    end

    // A request that pops must finish before the next item is classified,
    // since the pop may re-arm the group or change the refill run.
    assign in_ready  = cmd_ready && !pop_pend_reg;
    assign accept    = in_valid && in_ready;
    assign loading   = (heads_reg < n_eff);
    assign cmd_valid = in_valid && !pop_pend_reg;
    assign cmd_key   = key_value;

    always_comb
    begin
        heads_next = heads_reg;
        if (loading)
        begin
            cmd_run        = heads_reg[RW-1:0];
            cmd_flags.push = !run_empty;
            cmd_flags.pop  = ((heads_reg + CW'(1)) >= n_eff);
            heads_next     = heads_reg + CW'(1);
        end
        else
        begin
            cmd_run        = last_run;
            cmd_flags.push = !run_empty;
            cmd_flags.pop  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg <= RUN_COUNT_RST;
            heads_reg     <= '0;
            pop_pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                run_count_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                heads_reg    <= heads_next;
                pop_pend_reg <= cmd_flags.pop;
            end
            else if (stat.pop_done)
            begin
                pop_pend_reg <= 1'b0;
                if (stat.rearm)
                begin
                    heads_reg <= '0;
                end
            end
        end
    end
endmodule
`default_nettype wire

[design/kwm_back.sv]
// Back end: executes queued requests on the key store (push, linear min scan,
// pop with swap-from-last) and drives the output register. Uses kwm_pkg, kwm_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "k_way_merge_engine_macros.svh"
module kwm_back #(
    parameter int MAX_RUNS = kwm_pkg::DEF_MAX_RUNS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire logic [kwm_pkg::KEY_W-1:0]     cmd_key,
    input  wire logic [$clog2(MAX_RUNS)-1:0]   cmd_run,
    input  wire kwm_pkg::cmd_flags_t           cmd_flags,
    output kwm_pkg::back_stat_t                stat,
    output logic [$clog2(MAX_RUNS)-1:0]        last_run,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [kwm_pkg::KEY_W-1:0]          out_value,
    output logic [kwm_pkg::SRC_W-1:0]          source_run,
    output logic                               has_value,
    output logic                               merge_done
);
    import kwm_pkg::*;

    localparam int RW = $clog2(MAX_RUNS);
    localparam int CW = $clog2(MAX_RUNS + 1);
    localparam int EW = KEY_W + RW;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_MOVE, S_EMIT} state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [RW-1:0]   last_run_reg;
    logic [CW-1:0]   scan_idx_reg;
    logic            rd_pend_reg;
    logic [RW-1:0]   rd_idx_reg;
    logic            best_valid_reg;
    logic [KEY_W-1:0] best_key_reg;
    logic [RW-1:0]   best_run_reg;
    logic [RW-1:0]   best_idx_reg;
    logic            done_reg;
    logic            out_valid_reg, has_value_reg, merge_done_reg;
    logic [KEY_W-1:0] out_value_reg;
    logic [SRC_W-1:0] source_run_reg;

    logic            ram_we;
    logic [RW-1:0]   ram_waddr, ram_raddr;
    logic [EW-1:0]   ram_wdata, ram_rdata;
    logic [KEY_W-1:0] rd_key;
    logic [RW-1:0]   rd_run;
    logic            can_push, issue, better, out_free, emit;
    logic [CW-1:0]   count_push;

    assign rd_key    = ram_rdata[EW-1:RW];
    assign rd_run    = ram_rdata[RW-1:0];
    assign cmd_ready = (state_reg == S_IDLE);
    assign can_push  = cmd_flags.push && (count_reg < CW'(MAX_RUNS));
    assign count_push = can_push ? count_reg + CW'(1) : count_reg;
    assign issue     = (scan_idx_reg < count_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = (state_reg == S_EMIT) && out_free;

    // Ties on the key go to the lower run number.
    assign better = !best_valid_reg || (rd_key < best_key_reg) ||
                    ((rd_key == best_key_reg) && (rd_run < best_run_reg));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[RW-1:0];
        ram_wdata = {cmd_key, cmd_run};
        ram_raddr = scan_idx_reg[RW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                ram_we = cmd_valid && can_push;
            end
            S_LAST:
            begin
                ram_raddr = RW'(count_reg - CW'(1));
            end
            S_MOVE:
            begin
                // Last entry fills the hole left by the popped one.
                ram_we    = 1'b1;
                ram_waddr = best_idx_reg;
                ram_wdata = ram_rdata;
            end
            S_SCAN, S_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    kwm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_RUNS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            last_run_reg   <= '0;
            scan_idx_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            best_valid_reg <= 1'b0;
            best_key_reg   <= '0;
            best_run_reg   <= '0;
            best_idx_reg   <= '0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            source_run_reg <= '0;
            has_value_reg  <= 1'b0;
            merge_done_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        count_reg      <= count_push;
                        scan_idx_reg   <= '0;
                        rd_pend_reg    <= 1'b0;
                        best_valid_reg <= 1'b0;
                        if (cmd_flags.pop)
                        begin
                            if (count_push == '0)
                            begin
                                done_reg     <= 1'b1;
                                last_run_reg <= '0;
                                state_reg    <= S_EMIT;
                            end
                            else
                            begin
                                done_reg  <= 1'b0;
                                state_reg <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN:
                begin
                    if (rd_pend_reg && better)
                    begin
                        best_valid_reg <= 1'b1;
                        best_key_reg   <= rd_key;
                        best_run_reg   <= rd_run;
                        best_idx_reg   <= rd_idx_reg;
                    end
                    rd_pend_reg <= issue;
                    rd_idx_reg  <= scan_idx_reg[RW-1:0];
                    if (issue)
                    begin
                        scan_idx_reg <= scan_idx_reg + CW'(1);
                    end
                    else if (!rd_pend_reg)
                    begin
                        state_reg <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    state_reg <= S_MOVE;
                end
                S_MOVE:
                begin
                    count_reg    <= count_reg - CW'(1);
                    last_run_reg <= best_run_reg;
                    state_reg    <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        has_value_reg  <= !done_reg;
                        merge_done_reg <= done_reg;
                        out_value_reg  <= done_reg ? '0 : best_key_reg;
                        source_run_reg <= done_reg ? '0 : SRC_W'(best_run_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (!emit && out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.pop_done = emit;
    assign stat.rearm    = emit && done_reg;
    assign last_run      = last_run_reg;
    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign source_run    = source_run_reg;
    assign has_value     = has_value_reg;
    assign merge_done    = merge_done_reg;

    `KWM_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(MAX_RUNS), "queue count over capacity")
    `KWM_ASSERT_IMPL(a_out_kind, clk, rst_n, out_valid_reg, has_value_reg != merge_done_reg, "result is neither key nor done")
    `KWM_ASSERT_IMPL(a_done_empty, clk, rst_n, stat.rearm, count_reg == '0, "done issued with keys queued")
    `KWM_ASSERT_IMPL(a_scan_nonempty, clk, rst_n, state_reg == S_LAST, best_valid_reg && count_reg != '0, "pop without a candidate")
endmodule
`default_nettype wire

[design/k_way_merge_engine.sv]
// K-way merge engine: merges up to MAX_RUNS sorted runs of 64-bit keys.
// Usage: write run_count through cfg_wr_en/cfg_wr_data while the block is idle.
// Input channel (in_valid/in_ready) carries one request per item: first the
// heads of runs 0..N-1, N being run_count held to 1..MAX_RUNS (run_empty
// flags an empty run), after every popped key, the refill of run source_run.
// Output channel (out_valid/out_ready) carries one result per popping item:
// a key with its run (has_value) or, once the queue is dry, a done result
// (merge_done), after which the block starts a new group.
// Head-load items that do not pop are accepted one per cycle. A popping item
// has its result put in the output register after a minimum search over the
// keys queued after its push (at most 16 by default), a read of the last entry
// and its move into the hole; the search reads one store entry per cycle
// through the single read port of the key memory. A done result skips these
// steps. The next item is accepted in the cycle after the result is registered
// at the earliest, so no item is taken while a popping one is still in work.
// Reset clears the queue and group progress and sets run_count to 16.
// A stalled receiver holds the result in the output register; a further
// popping request then waits in the back end and input stays blocked.
// Uses kwm_pkg, kwm_front, kwm_cmd_fifo, kwm_back.
`timescale 1ns / 1ps
`default_nettype none
module k_way_merge_engine #(
    parameter int MAX_RUNS = kwm_pkg::DEF_MAX_RUNS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [kwm_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [kwm_pkg::KEY_W-1:0] key_value,
    input  wire logic                      run_empty,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [kwm_pkg::KEY_W-1:0]      out_value,
    output logic [kwm_pkg::SRC_W-1:0]      source_run,
    output logic                           has_value,
    output logic                           merge_done
);
    import kwm_pkg::*;

    localparam int RW = $clog2(MAX_RUNS);
    localparam int FW = KEY_W + RW + $bits(cmd_flags_t);

    logic             f_valid, f_ready, b_valid, b_ready;
    logic [KEY_W-1:0] f_key, b_key;
    logic [RW-1:0]    f_run, b_run, last_run;
    cmd_flags_t       f_flags, b_flags;
    back_stat_t       stat;
    logic [FW-1:0]    b_data;

    kwm_front #(.MAX_RUNS(MAX_RUNS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key_value   (key_value),
        .run_empty   (run_empty),
        .cmd_valid   (f_valid),
        .cmd_ready   (f_ready),
        .cmd_key     (f_key),
        .cmd_run     (f_run),
        .cmd_flags   (f_flags),
        .stat        (stat),
        .last_run    (last_run)
    );

    kwm_cmd_fifo #(.WIDTH(FW)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_key, f_run, f_flags}),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    assign b_key   = b_data[FW-1 -: KEY_W];
    assign b_run   = b_data[$bits(cmd_flags_t) +: RW];
    assign b_flags = b_data[$bits(cmd_flags_t)-1:0];

    kwm_back #(.MAX_RUNS(MAX_RUNS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (b_valid),
        .cmd_ready  (b_ready),
        .cmd_key    (b_key),
        .cmd_run    (b_run),
        .cmd_flags  (b_flags),
        .stat       (stat),
        .last_run   (last_run),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_value  (out_value),
        .source_run (source_run),
        .has_value  (has_value),
        .merge_done (merge_done)
    );
endmodule
`default_nettype wire

[bench/k_way_merge_engine_tb.sv]
// Self-checking bench for the k-way merge engine: random and directed merge groups.
// Depends on kwm_pkg and k_way_merge_engine; a small class predicts the popped keys.
`timescale 1ns / 1ps

class merge_scoreboard;
    logic [63:0] heap_keys[$];
    logic [3:0]  heap_runs[$];
    int unsigned heads_done;
    logic [3:0]  last_run;
    logic [4:0]  run_count;
    logic [63:0] want_value[$];
    logic [3:0]  want_run[$];
    logic        want_has[$];
    logic        want_done[$];
    int          mismatches;

    function new();
        heads_done = 0;
        last_run = 0;
        run_count = 5'd16;
        mismatches = 0;
    endfunction

    function int unsigned active_runs();
        int unsigned n;
        n = run_count;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        return n;
    endfunction

    function void push_key(logic [63:0] k, logic [3:0] r);
        if (heap_keys.size() >= 16) return;
        heap_keys = {heap_keys, k};
        heap_runs = {heap_runs, r};
    endfunction

    function void expect_result(logic [63:0] v, logic [3:0] r, logic h, logic d);
        want_value = {want_value, v};
        want_run   = {want_run, r};
        want_has   = {want_has, h};
        want_done  = {want_done, d};
    endfunction

    function void pop_smallest();
        int best;
        int last;
        if (heap_keys.size() == 0)
        begin
            expect_result(64'd0, 4'd0, 1'b0, 1'b1);
            heads_done = 0;
            last_run = 0;
            return;
        end
        best = 0;
        for (int i = 1; i < heap_keys.size(); i++)
        begin
            if (heap_keys[i] < heap_keys[best] ||
                (heap_keys[i] == heap_keys[best] && heap_runs[i] < heap_runs[best]))
                best = i;
        end
        expect_result(heap_keys[best], heap_runs[best], 1'b1, 1'b0);
        last_run = heap_runs[best];
        last = heap_keys.size() - 1;
        heap_keys[best] = heap_keys[last];
        heap_runs[best] = heap_runs[last];
        heap_keys.delete(last);
        heap_runs.delete(last);
    endfunction

    function void note_request(logic [63:0] k, logic empty);
        int unsigned n;
        n = active_runs();
        if (heads_done < n)
        begin
            if (!empty) push_key(k, heads_done[3:0]);
            heads_done++;
            if (heads_done == n) pop_smallest();
        end
        else
        begin
            if (!empty) push_key(k, last_run);
            pop_smallest();
        end
    endfunction

    function void check_result(logic [63:0] v, logic [3:0] r, logic h, logic d);
        if (want_value.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h run %0d", v, r);
            return;
        end
        if (v !== want_value[0] || r !== want_run[0] || h !== want_has[0]
            || d !== want_done[0])
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                         want_value[0], want_run[0], want_has[0], want_done[0],
                         v, r, h, d);
        end
        void'(want_value.pop_front()); void'(want_run.pop_front());
        void'(want_has.pop_front()); void'(want_done.pop_front());
    endfunction

    function int pending();
        return want_value.size();
    endfunction
endclass

module k_way_merge_engine_tb;
    import kwm_pkg::*;

    logic             clk = 0;
    logic             rst_n = 0;
    logic             cfg_wr_en = 0;
    logic [CFG_W-1:0] cfg_wr_data = 0;
    logic             in_valid = 0;
    logic             in_ready;
    logic [KEY_W-1:0] key_value = 0;
    logic             run_empty = 0;
    logic             out_valid;
    logic             out_ready = 0;
    logic [KEY_W-1:0] out_value;
    logic [SRC_W-1:0] source_run;
    logic             has_value;
    logic             merge_done;

    merge_scoreboard board = new();
    int          cycle_count = 0;
    int          idle_pct = 36;
    logic [63:0] run_tail[16];

    k_way_merge_engine dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .key_value(key_value), .run_empty(run_empty),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_value(out_value), .source_run(source_run),
        .has_value(has_value), .merge_done(merge_done)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The receiver stalls at random and checks every accepted result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(out_value, source_run, has_value, merge_done);
        out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Leaves in_valid high after the accepting edge, so a back-to-back request
    // needs no gap; an idle cycle or the drain takes it down.
    task automatic send_request(logic [63:0] k, logic empty);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid  <= 1;
        key_value <= k;
        run_empty <= empty;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_request(k, empty);
    endtask

    task automatic drain_and_settle();
        in_valid <= 0;
        while (board.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_run_count(logic [4:0] value);
        cfg_wr_en   <= 1;
        cfg_wr_data <= value;
        @(posedge clk);
        board.run_count = value;
        cfg_wr_en <= 0;
        @(posedge clk);
    endtask

    // Next key of a run: mostly ascending, sometimes a wild value.
    function automatic logic [63:0] next_key(int r);
        logic [63:0] step;
        if ($urandom_range(9) == 0) return {$urandom, $urandom};
        step = 64'($urandom_range(1000));
        if (run_tail[r] > 64'hFFFF_FFFF_FFFF_0000) run_tail[r] = 0;
        run_tail[r] = run_tail[r] + step;
        return run_tail[r];
    endfunction

    // Feeds one well-formed group: heads, then refills until done or max_items are sent.
    task automatic merge_group(int max_items);
        int n;
        int sent;
        int r;
        n = board.active_runs();
        for (int i = 0; i < 16; i++) run_tail[i] = 64'($urandom_range(5000));
        sent = 0;
        for (int i = 0; i < n; i++)
        begin
            send_request(next_key(i), ($urandom_range(9) == 0));
            sent++;
        end
        while (sent < max_items)
        begin
            if (board.heads_done == 0) break;
            r = board.last_run;
            send_request(next_key(r), ($urandom_range(3) == 0));
            sent++;
        end
        drain_and_settle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extreme keys, ties, empty runs, run count at its reset value.
        board.run_count = 5'd16;
        for (int i = 0; i < 16; i++)
            send_request((i % 3 == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0, (i == 5));
        for (int i = 0; i < 8; i++)
            send_request(64'h0, (i > 4));
        drain_and_settle();

        write_run_count(5'd0);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_request(64'h0, 1);
        send_request(64'h0, 1);
        drain_and_settle();
        write_run_count(5'd31);
        merge_group(40);
        write_run_count(5'd1);
        merge_group(20);

        // Random groups at assorted run counts; one stretch with no idling.
        for (int g = 0; g < 16; g++)
        begin
            idle_pct = (g >= 8 && g < 12) ? 0 : 36;
            if ($urandom_range(3) == 0)
            begin
                write_run_count(5'($urandom_range(31)));
            end
            merge_group(25);
            // Cut off at max_items: finish it so the next group starts clean.
            while (board.heads_done != 0)
            begin
                send_request(64'h0, 1);
                drain_and_settle();
            end
        end

        // Noise: unordered keys and random flags.
        write_run_count(5'd4);
        for (int i = 0; i < 40; i++)
            send_request({$urandom, $urandom}, 1'($urandom_range(1)));
        drain_and_settle();

        if (board.mismatches == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
